[sv/sil_pkg.sv]
// Shared types, constants and codes of the seek index lookup block.
package sil_pkg;

	// Table geometry.
	localparam int MAX_ENTRIES = 1024;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// Field widths.
	localparam int OP_W    = 2;
	localparam int SIZE_W  = 32;
	localparam int POS_W   = 48;
	localparam int STAT_W  = 2;
	localparam int ENTRY_W = 10;

	// Operation codes of an input item.
	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	// Status codes of a result item.
	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_BEYOND   = 2'd1,
		ST_FULL     = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SRCH,
		S_BACK,
		S_FIN,
		S_RESULT
	} state_t;

	// One table entry as stored in the index memory.
	typedef struct packed {
		logic [POS_W-1:0]  start_comp;
		logic [POS_W-1:0]  start_unc;
		logic [SIZE_W-1:0] size_unc;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	// Request from the sequencer to the index memory.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	// One finished result.
	typedef struct packed {
		status_t            status;
		logic [ENTRY_W-1:0] entry_index;
		logic [POS_W-1:0]   frame_file_offset;
		logic [POS_W-1:0]   frame_data_start;
		logic [POS_W-1:0]   skip_bytes;
	} res_t;

endpackage

[sv/sil_in_if.sv]
// Request channel of the seek index lookup block.
interface sil_in_if;
	logic                       valid;
	logic                       ready;
	logic [sil_pkg::OP_W-1:0]   operation;
	logic [sil_pkg::SIZE_W-1:0] compressed_size;
	logic [sil_pkg::SIZE_W-1:0] uncompressed_size;
	logic [sil_pkg::POS_W-1:0]  query_position;

	modport source (
		output valid, operation, compressed_size, uncompressed_size, query_position,
		input  ready
	);
	modport sink (
		input  valid, operation, compressed_size, uncompressed_size, query_position,
		output ready
	);
endinterface

[sv/sil_out_if.sv]
// Result channel of the seek index lookup block.
interface sil_out_if;
	logic                        valid;
	logic                        ready;
	logic [sil_pkg::STAT_W-1:0]  status;
	logic [sil_pkg::ENTRY_W-1:0] entry_index;
	logic [sil_pkg::POS_W-1:0]   frame_file_offset;
	logic [sil_pkg::POS_W-1:0]   frame_data_start;
	logic [sil_pkg::POS_W-1:0]   skip_bytes;

	modport source (
		output valid, status, entry_index, frame_file_offset, frame_data_start, skip_bytes,
		input  ready
	);
	modport sink (
		input  valid, status, entry_index, frame_file_offset, frame_data_start, skip_bytes,
		output ready
	);
endinterface

[sv/sil_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module sil_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/sil_seq.sv]
// Sequencer of the seek index lookup: appends, clears, binary search and step back.
module sil_seq (
	input  logic              clk,
	input  logic              arst_n,
	sil_in_if.sink            req,
	output sil_pkg::ram_req_t ram_req,
	input  sil_pkg::entry_t   rd,
	output logic              res_valid,
	output sil_pkg::res_t     res,
	input  logic              res_take
);

	localparam int CNT_W = sil_pkg::CNT_W;
	localparam int IDX_W = sil_pkg::IDX_W;
	localparam int POS_W = sil_pkg::POS_W;

	sil_pkg::state_t state_q, state_d;

	// Latched input item.
	logic [sil_pkg::OP_W-1:0]   op_q;
	logic [sil_pkg::SIZE_W-1:0] csz_q;
	logic [sil_pkg::SIZE_W-1:0] usz_q;
	logic [POS_W-1:0]           pos_q;

	// Table bookkeeping.
	logic [CNT_W-1:0] count_q, count_d;
	logic [POS_W-1:0] tot_u_q, tot_u_d;
	logic [POS_W-1:0] tot_c_q, tot_c_d;

	// Search window and probe.
	logic [CNT_W-1:0] lo_q, lo_d;
	logic [CNT_W-1:0] hi_q, hi_d;
	logic [IDX_W-1:0] mid_q, mid_d;

	sil_pkg::res_t res_q, res_d;

	logic accept;

	assign req.ready = (state_q == sil_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;
	assign res_valid = (state_q == sil_pkg::S_RESULT);
	assign res       = res_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sil_pkg::S_IDLE;
			count_q <= '0;
			tot_u_q <= '0;
			tot_c_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			tot_u_q <= tot_u_d;
			tot_c_q <= tot_c_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.operation;
			csz_q <= req.compressed_size;
			usz_q <= req.uncompressed_size;
			pos_q <= req.query_position;
		end
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		mid_q <= mid_d;
		res_q <= res_d;
	end

	// Next state, memory requests and results.
	always_comb begin
		logic [POS_W:0]   sum_u;
		logic [POS_W:0]   sum_c;
		logic [POS_W:0]   end_u;
		logic [CNT_W-1:0] nlo;
		logic [CNT_W-1:0] nhi;
		logic [CNT_W:0]   msum;
		logic [CNT_W-1:0] cand;
		logic             start_back;

		state_d    = state_q;
		count_d    = count_q;
		tot_u_d    = tot_u_q;
		tot_c_d    = tot_c_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		mid_d      = mid_q;
		res_d      = res_q;
		ram_req    = '0;
		start_back = 1'b0;
		cand       = lo_q;
		nlo        = lo_q;
		nhi        = hi_q;

		sum_u = {1'b0, tot_u_q} + (POS_W + 1)'(usz_q);
		sum_c = {1'b0, tot_c_q} + (POS_W + 1)'(csz_q);
		end_u = {1'b0, rd.start_unc} + (POS_W + 1)'(rd.size_unc);
		msum  = '0;

		unique case (state_q)
			sil_pkg::S_IDLE: begin
				if (accept) begin
					state_d = sil_pkg::S_EXEC;
				end
			end

			sil_pkg::S_EXEC: begin
				res_d   = '0;
				state_d = sil_pkg::S_RESULT;
				case (op_q)
					sil_pkg::OP_CLEAR: begin
						count_d = '0;
						tot_u_d = '0;
						tot_c_d = '0;
					end
					sil_pkg::OP_APPEND: begin
						if (count_q >= CNT_W'(sil_pkg::MAX_ENTRIES)) begin
							res_d.status = sil_pkg::ST_FULL;
						end else if (sum_u[POS_W] || sum_c[POS_W]) begin
							res_d.status = sil_pkg::ST_OVERFLOW;
						end else begin
							ram_req.we               = 1'b1;
							ram_req.waddr            = IDX_W'(count_q);
							ram_req.wdata.start_comp = tot_c_q;
							ram_req.wdata.start_unc  = tot_u_q;
							ram_req.wdata.size_unc   = usz_q;
							res_d.entry_index        = sil_pkg::ENTRY_W'(count_q);
							res_d.frame_file_offset  = tot_c_q;
							res_d.frame_data_start   = tot_u_q;
							count_d = count_q + CNT_W'(1);
							tot_u_d = sum_u[POS_W-1:0];
							tot_c_d = sum_c[POS_W-1:0];
						end
					end
					sil_pkg::OP_QUERY: begin
						if (pos_q >= tot_u_q) begin
							// Empty table or position past the last frame.
							res_d.status = sil_pkg::ST_BEYOND;
						end else begin
							lo_d          = '0;
							hi_d          = count_q;
							mid_d         = IDX_W'(count_q >> 1);
							ram_req.re    = 1'b1;
							ram_req.raddr = IDX_W'(count_q >> 1);
							state_d       = sil_pkg::S_SRCH;
						end
					end
					default: begin
					end
				endcase
			end

			// Entry at mid_q is on the read port.
			sil_pkg::S_SRCH: begin
				if (pos_q < rd.start_unc) begin
					nhi = CNT_W'(mid_q);
				end else if ({1'b0, pos_q} >= end_u) begin
					nlo = CNT_W'(mid_q) + CNT_W'(1);
				end else begin
					start_back = 1'b1;
					cand       = CNT_W'(mid_q);
				end
				if (!start_back) begin
					if (nlo < nhi) begin
						msum          = {1'b0, nlo} + {1'b0, nhi};
						lo_d          = nlo;
						hi_d          = nhi;
						mid_d         = IDX_W'(msum >> 1);
						ram_req.re    = 1'b1;
						ram_req.raddr = IDX_W'(msum >> 1);
					end else begin
						start_back = 1'b1;
						cand       = (nlo >= count_q) ? (count_q - CNT_W'(1)) : nlo;
					end
				end
			end

			// Entry lo_q - 1 is on the read port.
			sil_pkg::S_BACK: begin
				if (rd.size_unc == '0) begin
					start_back = 1'b1;
					cand       = lo_q - CNT_W'(1);
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = IDX_W'(lo_q);
					state_d       = sil_pkg::S_FIN;
				end
			end

			// Entry lo_q is on the read port.
			sil_pkg::S_FIN: begin
				res_d.status            = sil_pkg::ST_OK;
				res_d.entry_index       = sil_pkg::ENTRY_W'(lo_q);
				res_d.frame_file_offset = rd.start_comp;
				res_d.frame_data_start  = rd.start_unc;
				res_d.skip_bytes        = pos_q - rd.start_unc;
				state_d                 = sil_pkg::S_RESULT;
			end

			sil_pkg::S_RESULT: begin
				if (res_take) begin
					state_d = sil_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = sil_pkg::S_IDLE;
			end
		endcase

		// Step back over metadata frames: look at the entry before the candidate.
		if (start_back) begin
			lo_d       = cand;
			ram_req.re = 1'b1;
			if (cand == '0) begin
				ram_req.raddr = '0;
				state_d       = sil_pkg::S_FIN;
			end else begin
				ram_req.raddr = IDX_W'(cand - CNT_W'(1));
				state_d       = sil_pkg::S_BACK;
			end
		end
	end

endmodule

[sv/seek_index_lookup.sv]
// Top level of the seek index lookup: sequencer, index memory and output register.
//
//   Channel  Modport  Moves
//   req      sink     operation, compressed_size, uncompressed_size, query_position
//   rsp      source   status, entry_index, frame_file_offset, frame_data_start, skip_bytes
//
// Clear, append and unused operations pass from the request through execution to the
// result state. A query adds the search and step-back states; each search or step-back
// probe is one memory read, and a last read fetches the found entry.
// Reset empties the table at once; the memory itself is not cleared.
// A result waits in the output register while rsp stalls, and the next request is
// taken meanwhile; the sequencer holds its own result only if that register is full.
module seek_index_lookup (
	input logic       clk,
	input logic       arst_n,
	sil_in_if.sink    req,
	sil_out_if.source rsp
);

	sil_pkg::ram_req_t ram_req;
	logic [sil_pkg::ENTRY_BITS-1:0] ram_rdata;

	logic          res_valid;
	logic          res_take;
	sil_pkg::res_t res;

	logic          out_valid_q;
	sil_pkg::res_t out_q;

	// Index memory holding one entry per frame.
	sil_ram #(
		.WIDTH (sil_pkg::ENTRY_BITS),
		.DEPTH (sil_pkg::MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	sil_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ram_req   (ram_req),
		.rd        (sil_pkg::entry_t'(ram_rdata)),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	// A result moves into the output register when it is empty or being drained.
	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.status            = out_q.status;
	assign rsp.entry_index       = out_q.entry_index;
	assign rsp.frame_file_offset = out_q.frame_file_offset;
	assign rsp.frame_data_start  = out_q.frame_data_start;
	assign rsp.skip_bytes        = out_q.skip_bytes;

`ifndef SYNTHESIS
	// After a request transfer the sequencer is not ready in the following cycle.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while an item is in work");

	// A result handed over always shows up on the result channel.
	a_take_shows: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> rsp.valid)
		else $error("result handed over but not presented");

	// A drained output register empties unless a new result fills it.
	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && !res_take |=> !rsp.valid)
		else $error("result presented twice");

	// The sequencer never accepts a request while its result is still pending.
	a_no_req_pending: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req.ready)
		else $error("request ready while result pending");
`endif

endmodule

[tb/sv/seek_index_lookup_test.sv]
// Self-checking testbench of the seek index lookup: random append, query and clear traffic.
`timescale 1ns / 1ps

module seek_index_lookup_test;

	// The one operation code that the package leaves unnamed; the block ignores it but for an all-zero result.
	localparam logic [sil_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int RAND_ITEMS  = 1280;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 64;
	localparam int FILL_EPISODE = 4;

	// One request as queued for the driver, with the idling that goes with it.
	typedef struct {
		logic [sil_pkg::OP_W-1:0]   op;
		logic [sil_pkg::SIZE_W-1:0] csize;
		logic [sil_pkg::SIZE_W-1:0] usize;
		logic [sil_pkg::POS_W-1:0]  pos;
		bit                         drain;
		int                         gap_pct;
		int                         stall_pct;
	} lookup_req_t;

	logic clk;
	logic arst_n;

	sil_in_if  req ();
	sil_out_if rsp ();

	seek_index_lookup uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	lookup_req_t   pending_q[$];
	lookup_req_t   cur_req;
	sil_pkg::res_t lookup_expect[$];
	int            recv_stall_pct;
	int            mismatches;
	int            quiet_cycles;

	// Frame index as the block should hold it.
	logic [sil_pkg::SIZE_W-1:0] unc_size_tab [sil_pkg::MAX_ENTRIES];
	logic [sil_pkg::POS_W-1:0]  unc_start_tab[sil_pkg::MAX_ENTRIES];
	logic [sil_pkg::POS_W-1:0]  comp_start_tab[sil_pkg::MAX_ENTRIES];
	int                         idx_count;
	logic [sil_pkg::POS_W-1:0]  unc_total;
	logic [sil_pkg::POS_W-1:0]  comp_total;

	// Light copy of the index used to aim the generated queries and to pace the table fill.
	int                        gen_count;
	logic [sil_pkg::POS_W:0]   gen_total;
	logic [sil_pkg::POS_W-1:0] gen_start[sil_pkg::MAX_ENTRIES];
	int                        gen_gap;
	int                        gen_stall;
	int                        queued_items;

	// Works out the result of one transferred request and updates the index.
	task automatic predict_lookup(input lookup_req_t it);
		sil_pkg::res_t           r;
		logic [sil_pkg::POS_W:0] nu;
		logic [sil_pkg::POS_W:0] nc;
		int           lo;
		int           hi;
		int           mid;
		bit           hit;
		r = '0;
		case (it.op)
		sil_pkg::OP_CLEAR: begin
			idx_count  = 0;
			unc_total  = '0;
			comp_total = '0;
		end
		sil_pkg::OP_APPEND: begin
			nu = {1'b0, unc_total} + it.usize;
			nc = {1'b0, comp_total} + it.csize;
			if (idx_count >= sil_pkg::MAX_ENTRIES) begin
				r.status = sil_pkg::ST_FULL;
			end else if (nu[sil_pkg::POS_W] || nc[sil_pkg::POS_W]) begin
				r.status = sil_pkg::ST_OVERFLOW;
			end else begin
				unc_size_tab[idx_count]   = it.usize;
				unc_start_tab[idx_count]  = unc_total;
				comp_start_tab[idx_count] = comp_total;
				r.entry_index       = idx_count[sil_pkg::ENTRY_W-1:0];
				r.frame_file_offset = comp_total;
				r.frame_data_start  = unc_total;
				unc_total  = nu[sil_pkg::POS_W-1:0];
				comp_total = nc[sil_pkg::POS_W-1:0];
				idx_count++;
			end
		end
		sil_pkg::OP_QUERY: begin
			if (idx_count == 0 || it.pos >= unc_total) begin
				r.status = sil_pkg::ST_BEYOND;
			end else begin
				// Binary search for the frame whose span covers the position.
				lo  = 0;
				hi  = idx_count;
				hit = 1'b0;
				while (lo < hi && !hit) begin
					mid = (lo + hi) / 2;
					if (it.pos < unc_start_tab[mid]) begin
						hi = mid;
					end else if ({1'b0, it.pos} >=
							{1'b0, unc_start_tab[mid]} + unc_size_tab[mid]) begin
						lo = mid + 1;
					end else begin
						lo  = mid;
						hit = 1'b1;
					end
				end
				if (lo >= idx_count)
					lo = idx_count - 1;
				// Step back over the metadata frames just before it.
				while (lo > 0 && unc_size_tab[lo-1] == '0)
					lo--;
				r.entry_index       = lo[sil_pkg::ENTRY_W-1:0];
				r.frame_file_offset = comp_start_tab[lo];
				r.frame_data_start  = unc_start_tab[lo];
				r.skip_bytes        = it.pos - unc_start_tab[lo];
			end
		end
		default: ;
		endcase
		lookup_expect.push_back(r);
	endtask

	function automatic void check_field(input string name,
			input logic [sil_pkg::POS_W-1:0] want, input logic [sil_pkg::POS_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Compares one result transfer with the oldest expectation.
	task automatic check_result();
		sil_pkg::res_t want;
		if (lookup_expect.size() == 0) begin
			$error("result transfer with nothing expected: status %0d", rsp.status);
			mismatches++;
		end else begin
			want = lookup_expect.pop_front();
			check_field("status", sil_pkg::POS_W'(want.status), sil_pkg::POS_W'(rsp.status));
			check_field("entry_index", sil_pkg::POS_W'(want.entry_index),
				sil_pkg::POS_W'(rsp.entry_index));
			check_field("frame_file_offset", want.frame_file_offset, rsp.frame_file_offset);
			check_field("frame_data_start", want.frame_data_start, rsp.frame_data_start);
			check_field("skip_bytes", want.skip_bytes, rsp.skip_bytes);
		end
	endtask

	function automatic logic [sil_pkg::POS_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[sil_pkg::POS_W-1:0];
	endfunction

	// Mostly small frames, a fair share of metadata frames, now and then huge ones.
	function automatic logic [sil_pkg::SIZE_W-1:0] rand_usize();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return '0;
		else if (r < 65)
			return $urandom_range(4096, 1);
		else if (r < 85)
			return $urandom_range(1 << 20, 1);
		else if (r < 95)
			return $urandom();
		return '1;
	endfunction

	function automatic logic [sil_pkg::SIZE_W-1:0] rand_csize();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		else if (r < 80)
			return $urandom_range(65535, 1);
		else if (r < 95)
			return $urandom();
		return '1;
	endfunction

	// Positions aimed at frame edges, the end of the data and well past it.
	function automatic logic [sil_pkg::POS_W-1:0] rand_pos();
		int                        r;
		logic [sil_pkg::POS_W-1:0] s;
		if (gen_count == 0 || gen_total == '0)
			return rand48();
		r = $urandom_range(99);
		s = gen_start[$urandom_range(gen_count - 1)];
		if (r < 30)
			return rand48() % gen_total[sil_pkg::POS_W-1:0];
		else if (r < 50)
			return s;
		else if (r < 60)
			return (s == '0) ? s : s - 1'b1;
		else if (r < 70)
			return gen_total[sil_pkg::POS_W-1:0] - 1'b1;
		else if (r < 78)
			return '0;
		else if (r < 90)
			return gen_total[sil_pkg::POS_W-1:0];
		return rand48();
	endfunction

	// Queues one request and follows its effect on the table size and data length.
	function automatic void queue_item(input logic [sil_pkg::OP_W-1:0] op,
			input logic [sil_pkg::SIZE_W-1:0] csize, input logic [sil_pkg::SIZE_W-1:0] usize,
			input logic [sil_pkg::POS_W-1:0] pos, input bit drain);
		lookup_req_t it;
		it.op        = op;
		it.csize     = csize;
		it.usize     = usize;
		it.pos       = pos;
		it.drain     = drain;
		it.gap_pct   = gen_gap;
		it.stall_pct = gen_stall;
		pending_q.push_back(it);
		queued_items++;
		if (op == sil_pkg::OP_CLEAR) begin
			gen_count = 0;
			gen_total = '0;
		end else if (op == sil_pkg::OP_APPEND && gen_count < sil_pkg::MAX_ENTRIES) begin
			// With 1024 frames of at most 32 bits each, neither total can pass 48 bits.
			gen_start[gen_count] = gen_total[sil_pkg::POS_W-1:0];
			gen_total = gen_total + usize;
			gen_count++;
		end
	endfunction

	function automatic void queue_random(input logic [sil_pkg::OP_W-1:0] op, input bit drain);
		queue_item(op, rand_csize(), rand_usize(),
			(op == sil_pkg::OP_QUERY) ? rand_pos() : rand48(), drain);
	endfunction

	// Idling of the phase that the given count of random items falls into.
	function automatic void set_phase(input int done);
		case (done * 4 / RAND_ITEMS)
		0: begin gen_gap = 0;  gen_stall = 0;  end
		1: begin gen_gap = 45; gen_stall = 0;  end
		2: begin gen_gap = 0;  gen_stall = 45; end
		default: begin gen_gap = 25; gen_stall = 25; end
		endcase
	endfunction

	// Directed opening: empty table, metadata frames at the head and in the middle,
	// largest sizes, frame edges, the end of the data, clear and the unused code.
	function automatic void queue_directed();
		queue_item(sil_pkg::OP_QUERY, '0, '0, '0, 1'b0);
		queue_item(OP_UNUSED, '1, '1, '1, 1'b0);
		queue_item(sil_pkg::OP_APPEND, '0, '0, '0, 1'b0);
		queue_item(sil_pkg::OP_APPEND, 32'd100, '0, '0, 1'b0);
		queue_item(sil_pkg::OP_APPEND, '1, '1, '0, 1'b0);
		queue_item(sil_pkg::OP_APPEND, 32'd10, 32'd1, '0, 1'b0);
		queue_item(sil_pkg::OP_APPEND, '0, '0, '0, 1'b0);
		queue_item(sil_pkg::OP_APPEND, 32'd5, 32'd1000, '0, 1'b0);
		queue_item(sil_pkg::OP_QUERY, '0, '0, '0, 1'b0);
		queue_item(sil_pkg::OP_QUERY, '0, '0, 48'hFFFF_FFFE, 1'b0);
		queue_item(sil_pkg::OP_QUERY, '0, '0, 48'hFFFF_FFFF, 1'b0);
		queue_item(sil_pkg::OP_QUERY, '0, '0, 48'h1_0000_0000, 1'b0);
		queue_item(sil_pkg::OP_QUERY, '0, '0, gen_total[sil_pkg::POS_W-1:0] - 1'b1, 1'b0);
		queue_item(sil_pkg::OP_QUERY, '1, '1, gen_total[sil_pkg::POS_W-1:0], 1'b0);
		queue_item(sil_pkg::OP_QUERY, '0, '0, '1, 1'b0);
		queue_item(sil_pkg::OP_CLEAR, '1, '1, '1, 1'b0);
		queue_item(sil_pkg::OP_QUERY, '0, '0, '0, 1'b0);
		queue_item(sil_pkg::OP_APPEND, 32'd1, 32'd1, '0, 1'b0);
		queue_item(sil_pkg::OP_QUERY, '0, '0, '0, 1'b0);
		queue_item(OP_UNUSED, '0, '0, '0, 1'b0);
		queue_item(sil_pkg::OP_APPEND, '1, '1, '1, 1'b0);
		queue_item(sil_pkg::OP_QUERY, '0, '0, 48'h8000_0000, 1'b0);
		queue_item(sil_pkg::OP_QUERY, '0, '0, 48'h8000_0000_0000, 1'b0);
	endfunction

	// Random episodes of appends, queries, clears and unused codes, one filling the table past full.
	// The long fill runs through the idling phases item by item.
	function automatic void queue_episodes();
		int first;
		int episode;
		int len;
		int r;
		first   = queued_items;
		episode = 0;
		while (queued_items - first < RAND_ITEMS) begin
			set_phase(queued_items - first);
			if (episode == FILL_EPISODE) begin
				queue_random(sil_pkg::OP_CLEAR, 1'b1);
				while (gen_count < sil_pkg::MAX_ENTRIES) begin
					set_phase(queued_items - first);
					queue_random(sil_pkg::OP_APPEND, 1'b0);
				end
				repeat (4) queue_random(sil_pkg::OP_APPEND, 1'b0);
				repeat (40) queue_random(sil_pkg::OP_QUERY, 1'b0);
			end else begin
				if ($urandom_range(99) < 85)
					queue_random(sil_pkg::OP_CLEAR, $urandom_range(2) == 0);
				len = $urandom_range(60, 4);
				repeat (len) begin
					r = $urandom_range(99);
					if (r < 40)
						queue_random(sil_pkg::OP_APPEND, 1'b0);
					else if (r < 90)
						queue_random(sil_pkg::OP_QUERY, 1'b0);
					else if (r < 95)
						queue_random(OP_UNUSED, 1'b0);
					else
						queue_random(sil_pkg::OP_CLEAR, 1'b0);
				end
			end
			episode++;
		end
	endfunction

	// Driver: predicts each request transfer and presents the next queued request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready)
				predict_lookup(cur_req);
			if (!req.valid || req.ready) begin
				if (pending_q.size() > 0 && !(pending_q[0].drain && lookup_expect.size() > 0)
						&& $urandom_range(99) >= pending_q[0].gap_pct) begin
					cur_req = pending_q.pop_front();
					recv_stall_pct = cur_req.stall_pct;
					req.valid             <= 1'b1;
					req.operation         <= cur_req.op;
					req.compressed_size   <= cur_req.csize;
					req.uncompressed_size <= cur_req.usize;
					req.query_position    <= cur_req.pos;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transfer and stalls the result channel at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready)
				check_result();
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		clk                   = 1'b0;
		arst_n                = 1'b0;
		req.valid             = 1'b0;
		req.operation         = sil_pkg::OP_CLEAR;
		req.compressed_size   = '0;
		req.uncompressed_size = '0;
		req.query_position    = '0;
		rsp.ready             = 1'b0;
		recv_stall_pct        = 0;
		mismatches            = 0;
		quiet_cycles          = 0;
		idx_count             = 0;
		unc_total             = '0;
		comp_total            = '0;
		gen_count             = 0;
		gen_total             = '0;
		gen_gap               = 0;
		gen_stall             = 0;
		queued_items          = 0;
		queue_directed();
		queue_episodes();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go out and every result to come back.
		while (pending_q.size() > 0 || req.valid || lookup_expect.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[files.f]
sv/sil_pkg.sv
sv/sil_in_if.sv
sv/sil_out_if.sv
sv/sil_ram.sv
sv/sil_seq.sv
sv/seek_index_lookup.sv
tb/sv/seek_index_lookup_test.sv
